// ----- src/kf3d_pkg.sv -----
// ----------------------------------------------------------------------------
// kf3d_pkg
// Shared constants and helpers for the 3-D constant-velocity Kalman filter.
// ----------------------------------------------------------------------------
package kf3d_pkg;

  // Default width of one estimate entry (signed, 16 fraction bits).
  localparam int unsigned DataWidthDef = 32;

  // Fraction bits of covariance, gains and configuration values.
  localparam int unsigned FracBits = 30;

  // Width of a configuration register and of the register index.
  localparam int unsigned CfgWidth = 30;
  localparam int unsigned CfgIdxWidth = 2;

  // Register indexes.
  localparam logic [CfgIdxWidth-1:0] RegTimeStep    = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegProcessNoise = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegMeasureNoise = 2'd2;

  // Register reset values.
  localparam logic [CfgWidth-1:0] TimeStepRst     = 30'd10737418;
  localparam logic [CfgWidth-1:0] ProcessNoiseRst = 30'd10737;
  localparam logic [CfgWidth-1:0] MeasureNoiseRst = 30'd107374;

  // One in Q2.30.
  localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;

  // Saturate a 64-bit signed value to a signed range of the given width.
  function automatic logic signed [63:0] sat_w(input logic signed [63:0] v,
                                               input int unsigned bits);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

// ----- src/kf3d_mul.sv -----
// ----------------------------------------------------------------------------
// kf3d_mul
// Shift-add multiplier: (a * b) >> 30, rounded half away from zero.
// ----------------------------------------------------------------------------
module kf3d_mul
  import kf3d_pkg::*;
#(
  parameter int unsigned AW = 33
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [31:0]   b_i,
  output logic                 done_o,
  output logic signed [AW+2:0] res_o
);

  localparam int unsigned PW = AW + 32;

  logic [AW-1:0] ua_q;
  logic [PW-1:0] prod_q;
  logic          neg_q;
  logic [4:0]    cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [AW-1:0] ua_w;
  logic [31:0]   ub_w;
  logic [AW:0]   upper_w;
  logic [PW-1:0] rnd_w;
  logic [AW+2:0] mag_w;

  // Operand magnitudes.
  assign ua_w = a_i[AW-1] ? (~a_i + 1'b1) : a_i;
  assign ub_w = b_i[31] ? (~b_i + 1'b1) : b_i;

  // One partial product is added per cycle, low bit of b first.
  assign upper_w = {1'b0, prod_q[PW-1:32]} + (prod_q[0] ? {1'b0, ua_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ua_q   <= '0;
      prod_q <= '0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == 5'd31);
      if (start_i) begin
        ua_q   <= ua_w;
        prod_q <= {{AW{1'b0}}, ub_w};
        neg_q  <= a_i[AW-1] ^ b_i[31];
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        prod_q <= {upper_w, prod_q[31:1]};
        cnt_q  <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Rounding, scaling and sign of the finished product.
  assign rnd_w  = prod_q + (PW'(1) << (FracBits - 1));
  assign mag_w  = (AW + 3)'(rnd_w >> FracBits);
  assign res_o  = neg_q ? -$signed(mag_w) : $signed(mag_w);
  assign done_o = done_q;

endmodule

// ----- src/kf3d_div.sv -----
// ----------------------------------------------------------------------------
// kf3d_div
// Restoring divider for the gain: (num * 2^30) / den, rounded, saturated.
// ----------------------------------------------------------------------------
module kf3d_div
  import kf3d_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] q_o
);

  logic [62:0] quo_q;
  logic [31:0] rem_q;
  logic [31:0] den_q;
  logic        neg_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [31:0] un_w;
  logic [62:0] n_w;
  logic [32:0] r2_w;
  logic        ge_w;

  // Numerator magnitude scaled by 2^30, plus half the divisor for rounding.
  assign un_w = num_i[31] ? (~num_i + 1'b1) : num_i;
  assign n_w  = {1'b0, un_w, 30'd0} + {32'd0, den_i[31:1]};

  // One quotient bit per cycle.
  assign r2_w = {rem_q, quo_q[62]};
  assign ge_w = r2_w >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == 6'd62);
      if (start_i) begin
        quo_q  <= n_w;
        rem_q  <= '0;
        den_q  <= den_i;
        neg_q  <= num_i[31];
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= ge_w ? 32'(r2_w - {1'b0, den_q}) : r2_w[31:0];
        quo_q  <= {quo_q[61:0], ge_w};
        cnt_q  <= cnt_q + 6'd1;
        if (cnt_q == 6'd62) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Signed saturation of the quotient.
  always_comb begin
    if (neg_q) begin
      q_o = (quo_q > 63'h8000_0000) ? 32'sh8000_0000 : -$signed(quo_q[31:0]);
    end else begin
      q_o = (quo_q > 63'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quo_q[31:0]);
    end
  end

  assign done_o = done_q;

endmodule

// ----- src/kalman_filter_pos_vel_3d.sv -----
// ----------------------------------------------------------------------------
// kalman_filter_pos_vel_3d
// Six-state constant-velocity Kalman filter on 3-D position measurements.
// ----------------------------------------------------------------------------
// Each item is one position measurement; each produces one item with the
// position and velocity estimate. The first item only initializes the state.
// Every later item runs predict and update for the three axes in turn on
// one shared shift-add multiplier (ten operations per axis) and one
// restoring divider for the two gains. The input is stalled while an item
// is in work; a finished item waits in the output register while the next
// item is taken.
module kalman_filter_pos_vel_3d
  import kf3d_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [CfgWidth-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [31:0]         meas_x_i,
  input  logic signed [31:0]         meas_y_i,
  input  logic signed [31:0]         meas_z_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [31:0]         pos_x_o,
  output logic signed [31:0]         pos_y_o,
  output logic signed [31:0]         pos_z_o,
  output logic signed [31:0]         vel_x_o,
  output logic signed [31:0]         vel_y_o,
  output logic signed [31:0]         vel_z_o
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned AW = ((DW > 32) ? DW : 32) + 1;
  localparam int unsigned RW = AW + 3;

  // Sequencer states.
  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SIssue = 2'd1;
  localparam logic [1:0] SWait  = 2'd2;
  localparam logic [1:0] SOut   = 2'd3;

  // Steps within one axis.
  localparam logic [3:0] StEp  = 4'd0;
  localparam logic [3:0] StDvv = 4'd1;
  localparam logic [3:0] StA   = 4'd2;
  localparam logic [3:0] StPp  = 4'd3;
  localparam logic [3:0] StKp  = 4'd4;
  localparam logic [3:0] StKv  = 4'd5;
  localparam logic [3:0] StYp  = 4'd6;
  localparam logic [3:0] StYv  = 4'd7;
  localparam logic [3:0] StVp  = 4'd8;
  localparam logic [3:0] StVv  = 4'd9;
  localparam logic [3:0] StPpu = 4'd10;
  localparam logic [3:0] StPvu = 4'd11;

  logic [CfgWidth-1:0]     dt_q;
  logic [CfgWidth-1:0]     qn_q;
  logic [CfgWidth-1:0]     rn_q;

  logic [1:0]              state_q;
  logic [3:0]              step_q;
  logic [1:0]              axis_q;
  logic                    started_q;

  logic signed [31:0]      meas_q [3];
  logic signed [DW-1:0]    pos_q [3];
  logic signed [DW-1:0]    vel_q [3];
  logic signed [31:0]      pp_q [3];
  logic signed [31:0]      pv_q [3];
  logic signed [31:0]      vp_q [3];
  logic signed [31:0]      vv_q [3];

  logic signed [33:0]      dvv_q;
  logic signed [33:0]      a_q;
  logic signed [31:0]      s_q;
  logic signed [31:0]      kp_q;
  logic signed [31:0]      kv_q;
  logic signed [AW-1:0]    y_q;

  logic                    out_valid_q;
  logic signed [31:0]      out_q [6];

  logic signed [DW-1:0]    cur_pos;
  logic signed [DW-1:0]    cur_vel;
  logic signed [31:0]      cur_pp;
  logic signed [31:0]      cur_pv;
  logic signed [31:0]      cur_vp;
  logic signed [31:0]      cur_vv;

  logic                    in_acc;
  logic                    out_load;
  logic                    is_div;
  logic                    unit_done;
  logic                    last_axis;

  logic signed [63:0]      a64;
  logic signed [AW-1:0]    mul_a;
  logic signed [31:0]      mul_b;
  logic                    mul_start;
  logic                    mul_done;
  logic signed [RW-1:0]    mul_res;

  logic signed [31:0]      div_num;
  logic signed [31:0]      div_den;
  logic                    div_start;
  logic                    div_done;
  logic signed [31:0]      div_q;

  logic signed [63:0]      m64;
  logic signed [63:0]      s64;
  logic signed [63:0]      y64;
  logic signed [63:0]      pos_upd;
  logic signed [63:0]      vel_upd;
  logic signed [63:0]      pp_pred;
  logic signed [63:0]      pv_pred;
  logic signed [63:0]      vp_pred;
  logic signed [63:0]      vv_pred;
  logic signed [63:0]      pp_upd;
  logic signed [63:0]      pv_upd;
  logic signed [63:0]      vp_upd;
  logic signed [63:0]      vv_upd;
  logic signed [63:0]      ini [3];
  logic signed [63:0]      osat [6];

  // Per-axis working values.
  assign cur_pos = pos_q[axis_q];
  assign cur_vel = vel_q[axis_q];
  assign cur_pp  = pp_q[axis_q];
  assign cur_pv  = pv_q[axis_q];
  assign cur_vp  = vp_q[axis_q];
  assign cur_vv  = vv_q[axis_q];

  assign in_stall_o = (state_q != SIdle);
  assign in_acc     = in_valid_i && (state_q == SIdle);
  assign out_load   = (state_q == SOut) && (!out_valid_q || !out_stall_i);
  assign is_div     = (step_q == StKp) || (step_q == StKv);
  assign unit_done  = is_div ? div_done : mul_done;
  assign last_axis  = (axis_q == 2'd2);

  // Operand selection for the shared multiplier.
  always_comb begin
    a64   = 64'sd0;
    mul_b = 32'sd0;
    case (step_q)
      StEp: begin
        a64   = 64'(cur_vel);
        mul_b = $signed({2'b00, dt_q});
      end
      StDvv: begin
        a64   = 64'(cur_vv);
        mul_b = $signed({2'b00, dt_q});
      end
      StA: begin
        a64   = 64'(cur_pv) + 64'(cur_vp);
        mul_b = $signed({2'b00, dt_q});
      end
      StPp: begin
        a64   = 64'(dvv_q);
        mul_b = $signed({2'b00, dt_q});
      end
      StYp: begin
        a64   = y64;
        mul_b = kp_q;
      end
      StYv: begin
        a64   = 64'(y_q);
        mul_b = kv_q;
      end
      StVp: begin
        a64   = 64'(cur_pp);
        mul_b = kv_q;
      end
      StVv: begin
        a64   = 64'(cur_pv);
        mul_b = kv_q;
      end
      StPpu: begin
        a64   = 64'(cur_pp);
        mul_b = kp_q;
      end
      StPvu: begin
        a64   = 64'(cur_pv);
        mul_b = kp_q;
      end
      default: begin
        a64   = 64'sd0;
        mul_b = 32'sd0;
      end
    endcase
  end

  assign mul_a     = a64[AW-1:0];
  assign mul_start = (state_q == SIssue) && !is_div;

  // Gain divider operands; the first gain uses the fresh innovation variance.
  assign div_num   = (step_q == StKp) ? cur_pp : cur_vp;
  assign div_den   = (step_q == StKp) ? s64[31:0] : s_q;
  assign div_start = (state_q == SIssue) && is_div &&
                     ((step_q == StKv) || (s64 > 64'sd0));

  kf3d_mul #(
    .AW (AW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  kf3d_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // Saturated results of each step.
  always_comb begin
    m64     = 64'(mul_res);
    s64     = sat_w(64'(cur_pp) + 64'(rn_q), 32);
    y64     = 64'(meas_q[axis_q]) - 64'(cur_pos);
    pos_upd = sat_w(64'(cur_pos) + m64, DW);
    vel_upd = sat_w(64'(cur_vel) + m64, DW);
    pp_pred = sat_w(64'(cur_pp) + 64'(a_q) + m64 + 64'(qn_q), 32);
    pv_pred = sat_w(64'(cur_pv) + 64'(dvv_q), 32);
    vp_pred = sat_w(64'(cur_vp) + 64'(dvv_q), 32);
    vv_pred = sat_w(64'(cur_vv) + 64'(qn_q), 32);
    pp_upd  = sat_w(64'(cur_pp) - m64, 32);
    pv_upd  = sat_w(64'(cur_pv) - m64, 32);
    vp_upd  = sat_w(64'(cur_vp) - m64, 32);
    vv_upd  = sat_w(64'(cur_vv) - m64, 32);
    ini[0]  = sat_w(64'(meas_x_i), DW);
    ini[1]  = sat_w(64'(meas_y_i), DW);
    ini[2]  = sat_w(64'(meas_z_i), DW);
    for (int k = 0; k < 3; k++) begin
      osat[k]     = sat_w(64'(pos_q[k]), 32);
      osat[k + 3] = sat_w(64'(vel_q[k]), 32);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= TimeStepRst;
      qn_q <= ProcessNoiseRst;
      rn_q <= MeasureNoiseRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTimeStep:     dt_q <= cfg_data_i;
        RegProcessNoise: qn_q <= cfg_data_i;
        RegMeasureNoise: rn_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      step_q    <= StEp;
      axis_q    <= 2'd0;
      started_q <= 1'b0;
      dvv_q     <= '0;
      a_q       <= '0;
      s_q       <= '0;
      kp_q      <= '0;
      kv_q      <= '0;
      y_q       <= '0;
      for (int k = 0; k < 3; k++) begin
        meas_q[k] <= '0;
        pos_q[k]  <= '0;
        vel_q[k]  <= '0;
        pp_q[k]   <= OneQ30;
        pv_q[k]   <= '0;
        vp_q[k]   <= '0;
        vv_q[k]   <= OneQ30;
      end
    end else begin
      case (state_q)
        SIdle: begin
          if (in_acc) begin
            meas_q[0] <= meas_x_i;
            meas_q[1] <= meas_y_i;
            meas_q[2] <= meas_z_i;
            axis_q    <= 2'd0;
            step_q    <= StEp;
            if (!started_q) begin
              // First item: take the position, clear velocity, set covariance to identity.
              for (int k = 0; k < 3; k++) begin
                pos_q[k] <= ini[k][DW-1:0];
                vel_q[k] <= '0;
                pp_q[k]  <= OneQ30;
                pv_q[k]  <= '0;
                vp_q[k]  <= '0;
                vv_q[k]  <= OneQ30;
              end
              started_q <= 1'b1;
              state_q   <= SOut;
            end else begin
              state_q <= SIssue;
            end
          end
        end
        SIssue: begin
          if (step_q == StKp) begin
            s_q <= s64[31:0];
            if (s64 > 64'sd0) begin
              state_q <= SWait;
            end else begin
              // Non-positive innovation variance: both gains are zero.
              kp_q   <= '0;
              kv_q   <= '0;
              step_q <= StYp;
            end
          end else begin
            if (step_q == StYp) begin
              y_q <= y64[AW-1:0];
            end
            state_q <= SWait;
          end
        end
        SWait: begin
          if (unit_done) begin
            case (step_q)
              StEp:  pos_q[axis_q] <= pos_upd[DW-1:0];
              StDvv: dvv_q <= m64[33:0];
              StA:   a_q <= m64[33:0];
              StPp: begin
                pp_q[axis_q] <= pp_pred[31:0];
                pv_q[axis_q] <= pv_pred[31:0];
                vp_q[axis_q] <= vp_pred[31:0];
                vv_q[axis_q] <= vv_pred[31:0];
              end
              StKp:  kp_q <= div_q;
              StKv:  kv_q <= div_q;
              StYp:  pos_q[axis_q] <= pos_upd[DW-1:0];
              StYv:  vel_q[axis_q] <= vel_upd[DW-1:0];
              StVp:  vp_q[axis_q] <= vp_upd[31:0];
              StVv:  vv_q[axis_q] <= vv_upd[31:0];
              StPpu: pp_q[axis_q] <= pp_upd[31:0];
              StPvu: pv_q[axis_q] <= pv_upd[31:0];
              default: ;
            endcase
            // The last step of an axis moves on to the next axis or out.
            if (step_q == StPvu) begin
              step_q  <= StEp;
              axis_q  <= last_axis ? 2'd0 : axis_q + 2'd1;
              state_q <= last_axis ? SOut : SIssue;
            end else begin
              step_q  <= step_q + 4'd1;
              state_q <= SIssue;
            end
          end
        end
        SOut: begin
          if (out_load) begin
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // Output register: holds an item until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int k = 0; k < 6; k++) begin
        out_q[k] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        for (int k = 0; k < 6; k++) begin
          out_q[k] <= osat[k][31:0];
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_q[0];
  assign pos_y_o     = out_q[1];
  assign pos_z_o     = out_q[2];
  assign vel_x_o     = out_q[3];
  assign vel_y_o     = out_q[4];
  assign vel_z_o     = out_q[5];

endmodule
